### sv/srd_pkg.sv
// Package for the surveillance record decoder: payload structs, item codes,
// item length table. No dependencies.
package srd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } srd_in_t;

  typedef struct packed {
    logic [1:0]         record_kind;
    logic [7:0]         source_area;
    logic [7:0]         source_id;
    logic [15:0]        track_number;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        ground_speed;
    logic [15:0]        heading;
    logic [15:0]        polar_range;
    logic [15:0]        polar_azimuth;
    logic [15:0]        time_code;
    logic [8:0]         status_bits;
  } srd_out_t;

  localparam logic [4:0] IT_NONE   = 5'd0;
  localparam logic [4:0] IT_FSPEC2 = 5'd1;
  localparam logic [4:0] IT_FSPEC3 = 5'd2;
  localparam logic [4:0] IT_SACSIC = 5'd3;
  localparam logic [4:0] IT_DESC   = 5'd4;
  localparam logic [4:0] IT_TRKNUM = 5'd5;
  localparam logic [4:0] IT_CART   = 5'd6;
  localparam logic [4:0] IT_VEL    = 5'd7;
  localparam logic [4:0] IT_TIME_T = 5'd10;
  localparam logic [4:0] IT_SDI_T  = 5'd14;
  localparam logic [4:0] IT_POLAR  = 5'd15;
  localparam logic [4:0] IT_TIME_P = 5'd18;
  localparam logic [4:0] IT_SDI_P  = 5'd21;
  localparam logic [4:0] IT_C2CONF = 5'd26;
  localparam logic [4:0] IT_END    = 5'd28;
  localparam logic [3:0] LEN_VAR   = 4'd15;

  localparam logic [1:0] KIND_TRACK   = 2'd0;
  localparam logic [1:0] KIND_PLOT    = 2'd1;
  localparam logic [1:0] KIND_SERVICE = 2'd2;
  localparam logic [1:0] KIND_DISCARD = 2'd3;

  localparam logic [2:0] HDR_IDLE = 3'd0;
  localparam logic [2:0] HDR_LEN1 = 3'd1;
  localparam logic [2:0] HDR_LEN2 = 3'd2;
  localparam logic [2:0] HDR_FSP  = 3'd3;
  localparam logic [2:0] HDR_BODY = 3'd4;
  localparam logic [2:0] HDR_SKIP = 3'd5;

  function automatic logic [3:0] item_len(input logic [4:0] c);
    logic [3:0] r;
    unique case (c)
      5'd1, 5'd2, 5'd11, 5'd12, 5'd20, 5'd22, 5'd23: r = 4'd1;
      5'd3, 5'd5, 5'd8, 5'd9, 5'd10, 5'd13, 5'd16, 5'd17, 5'd18, 5'd19,
      5'd25: r = 4'd2;
      5'd24: r = 4'd3;
      5'd6, 5'd7, 5'd15: r = 4'd4;
      5'd27: r = 4'd8;
      5'd4, 5'd14, 5'd21, 5'd26: r = LEN_VAR;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/surveillance_record_decoder.sv
// Surveillance record decoder top level: byte sequencer and result register.
// Depends on srd_pkg.
//
// Use:
// - in channel (in_valid/in_ready/in_data) carries one byte item per cycle
//   while in_ready is high, with a block_start flag on the category byte of each block.
// - out channel (out_valid/out_ready/out_data) carries one decoded record
//   per finished record: track, plot, category-2 service or discarded.
// - Each byte is decoded combinationally; a result appears in the cycle after the
//   byte that completes its record. One byte per cycle sustained while the receiver does not stall.
// - The result sits in an output register; in_ready is high whenever that
//   register is empty or being taken this cycle, so while the receiver
//   stalls with a result waiting, the input is held as well.
// - Reset clears the sequencer, fspec and status state and the result
//   valid; the sticky track mode also returns to plot.
// - Items follow FSPEC order; the next present item is found by a priority
//   search over the 27 item presence bits.
module surveillance_record_decoder
  import srd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  srd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output srd_out_t out_data
);

  logic [2:0]  header_index, header_index_next;
  logic [7:0]  category, category_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  f1, f1_next, f2, f2_next, f3, f3_next;
  logic [1:0]  fsp, fsp_next;
  logic        track_mode, track_mode_next;
  logic [4:0]  item_step, item_step_next;
  logic [3:0]  item_byte, item_byte_next;
  logic [63:0] rf0, rf0_next, rf1, rf1_next, rf2, rf2_next;
  logic [8:0]  rstat, rstat_next;
  srd_out_t    res_next;
  logic        emit;

  assign in_ready = !out_valid || out_ready;
  wire take = in_valid && in_ready;

  // next present item after c, given current fspec/category/mode
  function automatic logic [4:0] next_item(
    input logic [4:0] c, input logic [7:0] a, input logic [7:0] b2,
    input logic [7:0] b3, input logic [1:0] fp, input logic [7:0] cat,
    input logic tm);
    logic [27:0] p;
    logic [7:0]  g2, g3;
    logic        c1, c2, trk, plt;
    logic [4:0]  r;
    g2 = fp[0] ? b2 : 8'h00;
    g3 = fp[1] ? b3 : 8'h00;
    c1 = cat == 8'd1; c2 = cat == 8'd2;
    trk = c1 && tm; plt = c1 && !tm;
    p = '0;
    p[1] = a[0]; p[2] = g2[0]; p[3] = a[7]; p[4] = c1 && a[6];
    p[5] = trk && a[5]; p[6] = trk && a[3]; p[7] = trk && a[2];
    p[8] = trk && a[4]; p[9] = trk && g2[7]; p[10] = trk && g2[6];
    p[11] = trk && g2[2]; p[12] = trk && g2[1]; p[13] = trk && g3[7];
    p[14] = trk && g3[2]; p[15] = plt && a[5]; p[16] = plt && a[4];
    p[17] = plt && a[3]; p[18] = plt && a[1]; p[19] = plt && g2[7];
    p[20] = plt && g2[1]; p[21] = plt && g3[2]; p[22] = c2 && a[6];
    p[23] = c2 && a[5]; p[24] = c2 && a[4]; p[25] = c2 && a[3];
    p[26] = c2 && a[2]; p[27] = c2 && g2[4];
    r = IT_END;
    for (int k = 27; k >= 1; k--) begin
      if (k > c && p[k]) r = 5'(k);
    end
    return r;
  endfunction

  function automatic srd_out_t mk(input logic [1:0] kind, input logic [63:0] a,
    input logic [63:0] b, input logic [63:0] c, input logic [8:0] st);
    srd_out_t o;
    o = '0;
    o.record_kind = kind;
    if (kind != KIND_DISCARD) begin
      o.source_area   = a[15:8];
      o.source_id     = a[7:0];
      o.track_number  = a[31:16];
      o.pos_x         = a[47:32];
      o.pos_y         = a[63:48];
      o.ground_speed  = b[15:0];
      o.heading       = b[31:16];
      o.polar_range   = b[47:32];
      o.polar_azimuth = b[63:48];
      o.time_code     = c[15:0];
      o.status_bits   = st;
    end
    return o;
  endfunction

  always_comb begin
    logic [7:0]  bt;
    logic [15:0] len;
    logic [3:0]  idx;
    logic [4:0]  c;
    logic [3:0]  total;
    logic        discard;
    logic [15:0] v;
    logic [1:0]  kind_now;
    bt = in_data.data_byte;
    header_index_next = header_index; category_next = category;
    bytes_left_next = bytes_left; f1_next = f1; f2_next = f2; f3_next = f3;
    fsp_next = fsp; track_mode_next = track_mode; item_step_next = item_step;
    item_byte_next = item_byte; rf0_next = rf0; rf1_next = rf1; rf2_next = rf2;
    rstat_next = rstat; emit = 1'b0; res_next = '0;
    len = '0; idx = '0; c = '0; total = '0; discard = 1'b0; v = '0;
    kind_now = (category == 8'd2) ? KIND_SERVICE :
               (track_mode ? KIND_TRACK : KIND_PLOT);
    if (in_data.block_start) begin
      if (header_index == HDR_BODY && item_step != IT_NONE) begin
        emit = 1'b1;
        res_next = mk(kind_now, rf0, rf1, rf2, rstat | 9'h100);
      end
      header_index_next = HDR_LEN1; category_next = bt;
      item_step_next = IT_NONE; item_byte_next = '0;
    end else begin
      unique case (header_index)
        HDR_LEN1: begin
          bytes_left_next = {bt, 8'h00}; header_index_next = HDR_LEN2;
        end
        HDR_LEN2: begin
          len = bytes_left | {8'h00, bt};
          bytes_left_next = (len >= 16'd4) ? len - 16'd4 : 16'd0;
          header_index_next = HDR_FSP;
        end
        HDR_FSP: begin
          f1_next = bt; item_step_next = IT_NONE;
          header_index_next = (bytes_left != 16'd0) ? HDR_BODY : HDR_IDLE;
        end
        HDR_BODY, HDR_SKIP: begin
          if (header_index == HDR_BODY) begin
            if (item_step == IT_NONE) begin
              rf0_next = '0; rf1_next = '0; rf2_next = '0; rstat_next = '0;
              fsp_next = '0; f2_next = '0; f3_next = '0;
              c = next_item(IT_NONE, f1, 8'h00, 8'h00, 2'b00, category,
                            track_mode);
              if ((category != 8'd1 && category != 8'd2) || c == IT_END) begin
                discard = 1'b1; item_step_next = IT_NONE;
              end else begin
                item_byte_next = item_len(c);
              end
            end else begin
              c = item_step;
            end
            if (discard) begin
              emit = 1'b1;
              res_next = mk(KIND_DISCARD, '0, '0, '0, '0);
              header_index_next = HDR_SKIP;
            end else begin
              // consume one byte of item c
              if (item_byte_next == LEN_VAR) begin
                total = 4'd1;
                if (c == IT_DESC) begin
                  track_mode_next = bt[7];
                  rstat_next[1] = 1'b1;
                  total = 4'd1 + {3'b000, bt[0]};
                end else if (c == IT_C2CONF) begin
                  total = 4'd1 + {3'b000, bt[0]};
                end else if (c == IT_SDI_T) begin
                  if (bt == 8'd7 || bt == 8'd14) total = bt[3:0];
                  else rstat_next[7] = 1'b1;
                end else if (c == IT_SDI_P) begin
                  if (bt == 8'd3 || bt == 8'd4) total = bt[3:0];
                  else rstat_next[7] = 1'b1;
                end
                item_byte_next = total - 4'd1;
              end else begin
                idx = item_len(c) - item_byte_next;
                if (item_byte_next != 4'd0) item_byte_next = item_byte_next - 4'd1;
                unique case (c)
                  IT_FSPEC2: begin f2_next = bt; fsp_next[0] = 1'b1; end
                  IT_FSPEC3: begin
                    f3_next = bt; fsp_next[1] = 1'b1;
                    if (bt[0]) rstat_next[6] = 1'b1;
                  end
                  IT_SACSIC: begin
                    rf0_next[15:0] = {rf0_next[7:0], bt}; rstat_next[0] = 1'b1;
                  end
                  IT_TRKNUM: begin
                    rf0_next[31:16] = {rf0_next[23:16], bt}; rstat_next[2] = 1'b1;
                  end
                  IT_CART: begin
                    if (idx < 4'd2) rf0_next[47:32] = {rf0_next[39:32], bt};
                    else rf0_next[63:48] = {rf0_next[55:48], bt};
                    rstat_next[3] = 1'b1;
                  end
                  IT_VEL: begin
                    if (idx < 4'd2) rf1_next[15:0] = {rf1_next[7:0], bt};
                    else rf1_next[31:16] = {rf1_next[23:16], bt};
                    rstat_next[4] = 1'b1;
                  end
                  IT_POLAR: begin
                    if (idx < 4'd2) rf1_next[47:32] = {rf1_next[39:32], bt};
                    else rf1_next[63:48] = {rf1_next[55:48], bt};
                    rstat_next[3] = 1'b1;
                  end
                  IT_TIME_T, IT_TIME_P: begin
                    rf2_next[15:0] = {rf2_next[7:0], bt}; rstat_next[5] = 1'b1;
                  end
                  default: ;
                endcase
              end
              item_step_next = c;
              if (item_byte_next == 4'd0) begin
                item_step_next = next_item(c, f1, f2_next, f3_next, fsp_next,
                                           category, track_mode_next);
                if (item_step_next == IT_END) begin
                  emit = 1'b1;
                  kind_now = (category == 8'd2) ? KIND_SERVICE :
                             (track_mode_next ? KIND_TRACK : KIND_PLOT);
                  res_next = mk(kind_now, rf0_next, rf1_next, rf2_next, rstat_next);
                  item_step_next = IT_NONE;
                end else begin
                  item_byte_next = item_len(item_step_next);
                end
              end
            end
          end
          v = (bytes_left != 16'd0) ? bytes_left - 16'd1 : 16'd0;
          bytes_left_next = v;
          if (v == 16'd0) begin
            if (header_index_next == HDR_BODY && item_step_next != IT_NONE) begin
              emit = 1'b1;
              kind_now = (category == 8'd2) ? KIND_SERVICE :
                         (track_mode_next ? KIND_TRACK : KIND_PLOT);
              res_next = mk(kind_now, rf0_next, rf1_next, rf2_next,
                            rstat_next | 9'h100);
            end
            header_index_next = HDR_IDLE; item_step_next = IT_NONE;
            item_byte_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index <= HDR_IDLE; category <= '0; bytes_left <= '0;
      f1 <= '0; f2 <= '0; f3 <= '0; fsp <= '0; track_mode <= 1'b0;
      item_step <= IT_NONE; item_byte <= '0; rstat <= '0;
      rf0 <= '0; rf1 <= '0; rf2 <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        header_index <= header_index_next; category <= category_next;
        bytes_left <= bytes_left_next; f1 <= f1_next; f2 <= f2_next;
        f3 <= f3_next; fsp <= fsp_next; track_mode <= track_mode_next;
        item_step <= item_step_next; item_byte <= item_byte_next;
        rstat <= rstat_next; rf0 <= rf0_next; rf1 <= rf1_next; rf2 <= rf2_next;
        if (emit) out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) out_data <= res_next;
  end

  // sequencer code stays in range
  a_hdr_range: assert property (@(posedge clk) disable iff (rst)
    header_index <= HDR_SKIP) else $error("header index out of range");
  // item step only active inside a body
  a_step_body: assert property (@(posedge clk) disable iff (rst)
    item_step != IT_NONE |-> header_index == HDR_BODY)
    else $error("item step outside body");
  // a result waiting is never overwritten
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result lost");
  // item step never reaches end marker in state
  a_step_end: assert property (@(posedge clk) disable iff (rst)
    item_step < IT_END) else $error("item step at end");

endmodule
